FILE: sv/hssb_pkg.sv
`default_nettype none
package hssb_pkg;

  // Heading units: centidegrees
  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic signed [16:0] FULL_TURN_S = 17'sd36000;
  localparam logic signed [16:0] HALF_TURN_S = 17'sd18000;

  // Source codes
  localparam logic [1:0] SRC_NONE    = 2'd0;
  localparam logic [1:0] SRC_FUSION  = 2'd1;
  localparam logic [1:0] SRC_COMPASS = 2'd2;

  // Selection modes
  localparam logic [1:0] MODE_AUTO    = 2'd0;
  localparam logic [1:0] MODE_COMPASS = 2'd1;
  localparam logic [1:0] MODE_FUSION  = 2'd2;
  localparam logic [1:0] MODE_DIAG    = 2'd3;

  // Configuration register indexes
  localparam logic CFG_SELECT_MODE = 1'b0;
  localparam logic CFG_BLEND_TIME  = 1'b1;

  // Blend divider geometry: magnitude of arc is at most 18000 (15 bits)
  localparam int MAG_W     = 15;
  localparam int TIME_W    = 32;
  localparam int PROD_W    = MAG_W + TIME_W;
  localparam int DIV_CNT_W = 4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Reduce a raw 16-bit heading into 0..35999
  function automatic logic [15:0] reduce_heading(input logic [15:0] hd);
    logic [15:0] res;
    res = (hd >= FULL_TURN) ? (hd - FULL_TURN) : hd;
    return res;
  endfunction

  // Shortest signed arc from one heading to another, -18000..17999
  function automatic logic signed [15:0] arc_between(input logic [15:0] from_hd,
                                                     input logic [15:0] to_hd);
    logic signed [16:0] d;
    d = $signed({1'b0, to_hd}) - $signed({1'b0, from_hd});
    if (d < 0) begin
      d = d + FULL_TURN_S;
    end
    if (d >= HALF_TURN_S) begin
      d = d - FULL_TURN_S;
    end
    return d[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/hssb_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in MAG_W bits (dividend < divisor << MAG_W).
module hssb_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [hssb_pkg::PROD_W-1:0]      dividend,
  input  wire logic [hssb_pkg::TIME_W-1:0]      divisor,
  output hssb_pkg::div_stat_t                   stat,
  output logic      [hssb_pkg::MAG_W-1:0]       quotient
);

  logic [hssb_pkg::TIME_W-1:0]    rem_r;
  logic [hssb_pkg::MAG_W-1:0]     quo_r;
  logic [hssb_pkg::TIME_W-1:0]    div_r;
  logic [hssb_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [hssb_pkg::TIME_W:0] trial;
  logic [hssb_pkg::TIME_W:0] trial_sub;
  logic                      ge;
  logic [hssb_pkg::TIME_W-1:0] rem_nxt;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial     = {rem_r, quo_r[hssb_pkg::MAG_W-1]};
    ge        = (trial >= {1'b0, div_r});
    trial_sub = trial - {1'b0, div_r};
    rem_nxt   = ge ? trial_sub[hssb_pkg::TIME_W-1:0] : trial[hssb_pkg::TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // Upper part of the dividend is already below the divisor
        rem_r  <= dividend[hssb_pkg::PROD_W-1:hssb_pkg::MAG_W];
        quo_r  <= dividend[hssb_pkg::MAG_W-1:0];
        div_r  <= divisor;
        cnt_r  <= hssb_pkg::DIV_CNT_W'(hssb_pkg::MAG_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[hssb_pkg::MAG_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

FILE: sv/heading_source_select_blend.sv
`default_nettype none
// Heading source select and blend.
// Input channel (in_*): one word per sample with fusion and compass readings
// and a millisecond timestamp. Output channel (out_*): one result word per
// input word, carrying the chosen heading, its source, quality and an
// optional transition record. Both channels use valid/stall.
// Configuration (cfg_*): index 0 select mode, index 1 blend time in ms;
// write only while the block is idle.
// Sequence: a sample that needs no blend arithmetic goes from acceptance
// through evaluation to the output stage. A sample inside a running blend
// also goes through a multiply step, a divider start and the restoring
// divider. The block takes one sample at a time: in_stall stays high
// from acceptance until the result is loaded into the output register.
// Reset clears the mode, blend time, source tracking and blend state.
// A stalled result holds in the output register; a finished sample waits
// in the pending result registers until the output register frees up, and in_stall stays high meanwhile.
module heading_source_select_blend (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_fusion_ok,
  input  wire logic        [15:0] in_fusion_heading,
  input  wire logic        [7:0]  in_fusion_quality,
  input  wire logic               in_compass_ok,
  input  wire logic        [15:0] in_compass_heading,
  input  wire logic        [7:0]  in_compass_quality,
  input  wire logic        [31:0] in_now_ms,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_heading_ok,
  output logic             [15:0] out_heading_out,
  output logic             [1:0]  out_active_src,
  output logic             [7:0]  out_quality_out,
  output logic                    out_switch_event,
  output logic             [1:0]  out_switch_from,
  output logic             [1:0]  out_switch_to,
  output logic signed      [15:0] out_switch_diff,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic        [31:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r;

  // Configuration
  logic [1:0]  mode_r;
  logic [31:0] blend_time_r;

  // Latched sample
  logic        f_ok_r, c_ok_r;
  logic [15:0] f_hd_r, c_hd_r;
  logic [7:0]  f_q_r, c_q_r;
  logic [31:0] now_r;

  // Tracking state
  logic [1:0]  cur_src_r;
  logic        blend_active_r;
  logic [31:0] blend_start_r;
  logic [31:0] blend_len_r;
  logic [15:0] blend_origin_r;
  logic [15:0] last_heading_r;

  // Blend arithmetic
  logic [hssb_pkg::MAG_W-1:0]  mag_r;
  logic                        neg_r;
  logic [31:0]                 elapsed_r;
  logic [hssb_pkg::PROD_W-1:0] prod_r;

  // Pending result
  logic               res_ok_r;
  logic [15:0]        res_hd_r;
  logic [1:0]         res_src_r;
  logic [7:0]         res_q_r;
  logic               res_ev_r;
  logic [1:0]         res_from_r;
  logic [1:0]         res_to_r;
  logic signed [15:0] res_diff_r;

  // Output register
  logic               out_valid_r;
  logic               out_ok_r;
  logic [15:0]        out_hd_r;
  logic [1:0]         out_src_r;
  logic [7:0]         out_q_r;
  logic               out_ev_r;
  logic [1:0]         out_from_r;
  logic [1:0]         out_to_r;
  logic signed [15:0] out_diff_r;

  // Divider
  logic                       div_start;
  hssb_pkg::div_stat_t        div_st;
  logic [hssb_pkg::MAG_W-1:0] div_q;

  // Evaluation terms
  logic [1:0]         desired;
  logic [15:0]        cand_hd;
  logic [7:0]         cand_q;
  logic               start_blend;
  logic               blend_on;
  logic [31:0]        bstart_eff;
  logic [31:0]        blen_eff;
  logic [15:0]        origin_eff;
  logic [31:0]        elapsed;
  logic               blend_end;
  logic signed [15:0] arc_new;
  logic signed [15:0] arc_blend;
  logic [15:0]        arc_mag;
  logic signed [16:0] ofs_sum;
  logic [15:0]        ofs_heading;
  logic               in_accept;
  logic               out_free;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign div_start = (state_r == S_DIVGO);

  // Pick the desired source and work out the blend decision
  always_comb begin
    case (mode_r) inside
      hssb_pkg::MODE_COMPASS: desired = c_ok_r ? hssb_pkg::SRC_COMPASS : hssb_pkg::SRC_NONE;
      hssb_pkg::MODE_FUSION:  desired = f_ok_r ? hssb_pkg::SRC_FUSION : hssb_pkg::SRC_NONE;
      hssb_pkg::MODE_AUTO, hssb_pkg::MODE_DIAG: begin
        desired = f_ok_r ? hssb_pkg::SRC_FUSION
                         : (c_ok_r ? hssb_pkg::SRC_COMPASS : hssb_pkg::SRC_NONE);
      end
      default: desired = hssb_pkg::SRC_NONE;
    endcase
    cand_hd     = (desired == hssb_pkg::SRC_FUSION) ? f_hd_r : c_hd_r;
    cand_q      = (desired == hssb_pkg::SRC_FUSION) ? f_q_r : c_q_r;
    start_blend = (desired != cur_src_r) && !blend_active_r;
    blend_on    = blend_active_r || start_blend;
    bstart_eff  = start_blend ? now_r : blend_start_r;
    blen_eff    = start_blend ? blend_time_r : blend_len_r;
    origin_eff  = start_blend ? last_heading_r : blend_origin_r;
    elapsed     = now_r - bstart_eff;
    blend_end   = (blen_eff == '0) || (elapsed >= blen_eff);
    arc_new     = hssb_pkg::arc_between(last_heading_r, cand_hd);
    arc_blend   = hssb_pkg::arc_between(origin_eff, cand_hd);
    arc_mag     = (arc_blend < 0) ? 16'(-arc_blend) : 16'(arc_blend);
  end

  // Apply the quotient offset around the circle
  always_comb begin
    if (neg_r) begin
      ofs_sum = $signed({1'b0, blend_origin_r}) - $signed({2'b0, div_q});
      if (ofs_sum < 0) begin
        ofs_sum = ofs_sum + hssb_pkg::FULL_TURN_S;
      end
    end else begin
      ofs_sum = $signed({1'b0, blend_origin_r}) + $signed({2'b0, div_q});
      if (ofs_sum >= hssb_pkg::FULL_TURN_S) begin
        ofs_sum = ofs_sum - hssb_pkg::FULL_TURN_S;
      end
    end
    ofs_heading = ofs_sum[15:0];
  end

  hssb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (blend_len_r),
    .stat     (div_st),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mode_r         <= hssb_pkg::MODE_AUTO;
      blend_time_r   <= '0;
      cur_src_r      <= hssb_pkg::SRC_NONE;
      blend_active_r <= 1'b0;
      blend_start_r  <= '0;
      blend_len_r    <= '0;
      blend_origin_r <= '0;
      last_heading_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          hssb_pkg::CFG_SELECT_MODE: mode_r       <= cfg_wdata[1:0];
          hssb_pkg::CFG_BLEND_TIME:  blend_time_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the output word once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            f_ok_r  <= in_fusion_ok;
            f_hd_r  <= hssb_pkg::reduce_heading(in_fusion_heading);
            f_q_r   <= in_fusion_quality;
            c_ok_r  <= in_compass_ok;
            c_hd_r  <= hssb_pkg::reduce_heading(in_compass_heading);
            c_q_r   <= in_compass_quality;
            now_r   <= in_now_ms;
            state_r <= S_EVAL;
          end
        end

        S_EVAL: begin
          res_ev_r   <= 1'b0;
          res_from_r <= hssb_pkg::SRC_NONE;
          res_to_r   <= hssb_pkg::SRC_NONE;
          res_diff_r <= '0;
          state_r    <= S_FIN;
          if (desired == hssb_pkg::SRC_NONE) begin
            // All sources lost
            res_ok_r       <= 1'b0;
            res_hd_r       <= '0;
            res_src_r      <= hssb_pkg::SRC_NONE;
            res_q_r        <= '0;
            res_ev_r       <= (cur_src_r != hssb_pkg::SRC_NONE);
            res_from_r     <= cur_src_r;
            cur_src_r      <= hssb_pkg::SRC_NONE;
            blend_active_r <= 1'b0;
          end else if (cur_src_r == hssb_pkg::SRC_NONE) begin
            // First source after none: snap
            res_ok_r       <= 1'b1;
            res_q_r        <= cand_q;
            res_src_r      <= desired;
            res_hd_r       <= cand_hd;
            cur_src_r      <= desired;
            last_heading_r <= cand_hd;
          end else begin
            res_ok_r  <= 1'b1;
            res_q_r   <= cand_q;
            res_src_r <= start_blend ? desired : cur_src_r;
            if (start_blend) begin
              blend_start_r  <= now_r;
              blend_len_r    <= blend_time_r;
              blend_origin_r <= last_heading_r;
              cur_src_r      <= desired;
              res_ev_r       <= 1'b1;
              res_from_r     <= cur_src_r;
              res_to_r       <= desired;
              res_diff_r     <= arc_new;
            end
            if (blend_on && !blend_end) begin
              // Blend in progress: scale the arc by elapsed time
              blend_active_r <= 1'b1;
              mag_r          <= arc_mag[hssb_pkg::MAG_W-1:0];
              neg_r          <= (arc_blend < 0);
              elapsed_r      <= elapsed;
              state_r        <= S_MUL;
            end else begin
              blend_active_r <= 1'b0;
              res_hd_r       <= cand_hd;
              last_heading_r <= cand_hd;
            end
          end
        end

        S_MUL: begin
          prod_r  <= hssb_pkg::PROD_W'(mag_r) * hssb_pkg::PROD_W'(elapsed_r);
          state_r <= S_DIVGO;
        end

        S_DIVGO: begin
          state_r <= S_DIV;
        end

        S_DIV: begin
          if (div_st.done) begin
            res_hd_r       <= ofs_heading;
            last_heading_r <= ofs_heading;
            state_r        <= S_FIN;
          end
        end

        S_FIN: begin
          // Hold until the output register frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_hd_r    <= res_hd_r;
            out_src_r   <= res_src_r;
            out_q_r     <= res_q_r;
            out_ev_r    <= res_ev_r;
            out_from_r  <= res_from_r;
            out_to_r    <= res_to_r;
            out_diff_r  <= res_diff_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_heading_ok   = out_ok_r;
  assign out_heading_out  = out_hd_r;
  assign out_active_src   = out_src_r;
  assign out_quality_out  = out_q_r;
  assign out_switch_event = out_ev_r;
  assign out_switch_from  = out_from_r;
  assign out_switch_to    = out_to_r;
  assign out_switch_diff  = out_diff_r;

  // A running blend always has a source behind it
  a_blend_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    blend_active_r |-> (cur_src_r != hssb_pkg::SRC_NONE))
    else $error("blend active with no source");

  // Emitted headings stay on the circle
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hd_r < hssb_pkg::FULL_TURN))
    else $error("heading out of range");

  // An invalid result carries zero heading and quality
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> ((out_hd_r == '0) && (out_q_r == '0)))
    else $error("invalid result with nonzero fields");

  // No record means empty record fields
  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ev_r) |->
      ((out_from_r == hssb_pkg::SRC_NONE) && (out_to_r == hssb_pkg::SRC_NONE) &&
       (out_diff_r == '0)))
    else $error("record fields set without an event");

  // Divider completion moves the sequencer on to the output stage
  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && div_st.done) |=> (state_r == S_FIN))
    else $error("divider result not taken");

endmodule
`default_nettype wire
